// File: src/block_dispatch_with_hash_chaining_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the block dispatcher
// Implication checks, same cycle and next cycle, with reset gating.
// ----------------------------------------------------------------------------
`ifndef BLOCK_DISPATCH_WITH_HASH_CHAINING_MACROS_SVH
`define BLOCK_DISPATCH_WITH_HASH_CHAINING_MACROS_SVH

`ifndef ASSERT_OFF
`define BDH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bdh assertion failed");
`define BDH_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bdh assertion failed");
`else
`define BDH_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BDH_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: src/bdh_pkg.sv
// ----------------------------------------------------------------------------
// bdh_pkg
// Shared types and constants of the block dispatcher.
// ----------------------------------------------------------------------------
package bdh_pkg;

    localparam int NUM_BLOCKS_DEF = 32;
    localparam int NUM_SLOTS_DEF  = 4;
    localparam int TAG_BITS_DEF   = 16;

    localparam int TAG_FIELD_W  = 16;
    localparam int SLOT_FIELD_W = 2;
    localparam int BLK_FIELD_W  = 5;

    typedef enum logic {
        OP_ALLOC      = 1'b0,
        OP_SLOT_EVENT = 1'b1
    } t_opcode;

    typedef struct packed {
        t_opcode                 opcode;
        logic [TAG_FIELD_W-1:0]  tag;
        logic [SLOT_FIELD_W-1:0] slot;
        logic                    finished;
    } t_in_word;

    typedef struct packed {
        logic                   alloc_ok;
        logic [BLK_FIELD_W-1:0] alloc_block;
        logic                   alloc_ready;
        logic                   dispatched;
        logic [BLK_FIELD_W-1:0] dispatch_block;
        logic                   freed;
        logic [BLK_FIELD_W-1:0] freed_block;
    } t_out_word;

endpackage

// File: src/block_dispatch_with_hash_chaining.sv
// ----------------------------------------------------------------------------
// block_dispatch_with_hash_chaining
// Work-block allocator and slot dispatcher with tag hazard chaining.
// ----------------------------------------------------------------------------
// Each input word yields exactly one result word. The block takes one word per
// cycle while the output is not stalled: the word is captured in an input
// register, the tag compare across all blocks and the free/ready priority picks
// run combinationally, and the result lands in an output register while the
// scheduler state updates on the same edge, so back-to-back words always see
// the state left by the one before. Fields that do not apply to a word read as
// zero. Tag value all-ones is the empty marker and never matches.
module block_dispatch_with_hash_chaining #(
    parameter int NUM_BLOCKS = bdh_pkg::NUM_BLOCKS_DEF,
    parameter int NUM_SLOTS  = bdh_pkg::NUM_SLOTS_DEF,
    parameter int TAG_BITS   = bdh_pkg::TAG_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  bdh_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bdh_pkg::t_out_word o_out_word
);

`include "block_dispatch_with_hash_chaining_macros.svh"

    localparam int IW  = $clog2(NUM_BLOCKS);
    localparam int BFW = bdh_pkg::BLK_FIELD_W;

    logic               r_in_valid;
    bdh_pkg::t_in_word  r_in_word;
    logic               r_out_valid;
    bdh_pkg::t_out_word r_out_word;
    bdh_pkg::t_out_word n_out_word;
    logic               proc;

    logic [NUM_BLOCKS-1:0] r_free_mask, n_free_mask;
    logic [NUM_BLOCKS-1:0] r_ready_mask, n_ready_mask;
    logic [IW-1:0]         r_last_alloc, n_last_alloc;
    logic [IW-1:0]         r_last_disp, n_last_disp;
    logic                  r_owner_vld [NUM_SLOTS];
    logic                  n_owner_vld [NUM_SLOTS];
    logic [IW-1:0]         r_owner_idx [NUM_SLOTS];
    logic [IW-1:0]         n_owner_idx [NUM_SLOTS];
    logic                  r_succ_vld  [NUM_BLOCKS];
    logic                  n_succ_vld  [NUM_BLOCKS];
    logic [IW-1:0]         r_succ_idx  [NUM_BLOCKS];
    logic [IW-1:0]         n_succ_idx  [NUM_BLOCKS];

    logic [TAG_BITS-1:0]  tag_in;
    logic                 free_found;
    logic [IW-1:0]        free_idx;
    logic                 rdy_found;
    logic [IW-1:0]        rdy_idx;
    logic                 tag_match;
    logic [IW-1:0]        tag_old;
    logic                 tag_alloc_we;
    logic                 tag_clear_we;
    logic [NUM_SLOTS-1:0] slot_sel;
    logic                 slot_ok;
    logic                 own_vld;
    logic [IW-1:0]        own_idx;
    logic                 have_next;
    logic [IW-1:0]        next_idx;

    assign proc        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !proc;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign tag_in      = r_in_word.tag[TAG_BITS-1:0];

    bdh_pick #(.N(NUM_BLOCKS)) u_free_pick (
        .i_mask  (r_free_mask),
        .i_limit (r_last_alloc),
        .o_found (free_found),
        .o_idx   (free_idx)
    );

    bdh_pick #(.N(NUM_BLOCKS)) u_ready_pick (
        .i_mask  (r_ready_mask),
        .i_limit (r_last_disp),
        .o_found (rdy_found),
        .o_idx   (rdy_idx)
    );

    bdh_tags #(.NUM_BLOCKS(NUM_BLOCKS), .TAG_BITS(TAG_BITS)) u_tags (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tag       (tag_in),
        .o_match     (tag_match),
        .o_match_idx (tag_old),
        .i_alloc_we  (tag_alloc_we),
        .i_alloc_idx (free_idx),
        .i_clear_we  (tag_clear_we),
        .i_clear_idx (own_idx)
    );

    // slot owner lookup
    always_comb begin
        own_vld = 1'b0;
        own_idx = '0;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            slot_sel[s] = ({1'b0, r_in_word.slot} == 3'(s));
            if (slot_sel[s]) begin
                own_vld = r_owner_vld[s];
                own_idx = r_owner_idx[s];
            end
        end
        slot_ok = |slot_sel;
    end

    always_comb begin
        n_free_mask  = r_free_mask;
        n_ready_mask = r_ready_mask;
        n_last_alloc = r_last_alloc;
        n_last_disp  = r_last_disp;
        n_owner_vld  = r_owner_vld;
        n_owner_idx  = r_owner_idx;
        n_succ_vld   = r_succ_vld;
        n_succ_idx   = r_succ_idx;
        n_out_word   = '0;
        tag_alloc_we = 1'b0;
        tag_clear_we = 1'b0;
        have_next    = 1'b0;
        next_idx     = '0;

        if (proc) begin
            case (r_in_word.opcode)
                bdh_pkg::OP_ALLOC: begin
                    if (free_found) begin
                        tag_alloc_we          = 1'b1;
                        n_free_mask[free_idx] = 1'b0;
                        if (tag_match) begin
                            n_succ_vld[tag_old] = 1'b1;
                            n_succ_idx[tag_old] = free_idx;
                        end else begin
                            n_ready_mask[free_idx] = 1'b1;
                        end
                        n_last_alloc           = free_idx;
                        n_out_word.alloc_ok    = 1'b1;
                        n_out_word.alloc_block = BFW'(free_idx);
                        n_out_word.alloc_ready = !tag_match;
                    end
                end
                bdh_pkg::OP_SLOT_EVENT: begin
                    if (slot_ok && !(own_vld && !r_in_word.finished)) begin
                        if (own_vld) begin
                            n_free_mask[own_idx]   = 1'b1;
                            tag_clear_we           = 1'b1;
                            n_out_word.freed       = 1'b1;
                            n_out_word.freed_block = BFW'(own_idx);
                            for (int s = 0; s < NUM_SLOTS; s++) begin
                                if (slot_sel[s]) begin
                                    n_owner_vld[s] = 1'b0;
                                end
                            end
                            if (r_succ_vld[own_idx]) begin
                                have_next           = 1'b1;
                                next_idx            = r_succ_idx[own_idx];
                                n_succ_vld[own_idx] = 1'b0;
                            end
                        end
                        if (!have_next && rdy_found) begin
                            have_next = 1'b1;
                            next_idx  = rdy_idx;
                        end
                        if (have_next) begin
                            n_ready_mask[next_idx]    = 1'b0;
                            n_last_disp               = next_idx;
                            n_out_word.dispatched     = 1'b1;
                            n_out_word.dispatch_block = BFW'(next_idx);
                            for (int s = 0; s < NUM_SLOTS; s++) begin
                                if (slot_sel[s]) begin
                                    n_owner_vld[s] = 1'b1;
                                    n_owner_idx[s] = next_idx;
                                end
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_free_mask  <= '1;
            r_ready_mask <= '0;
            r_last_alloc <= '0;
            r_last_disp  <= '0;
            for (int s = 0; s < NUM_SLOTS; s++) begin
                r_owner_vld[s] <= 1'b0;
                r_owner_idx[s] <= '0;
            end
            for (int b = 0; b < NUM_BLOCKS; b++) begin
                r_succ_vld[b] <= 1'b0;
                r_succ_idx[b] <= '0;
            end
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (proc) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            r_free_mask  <= n_free_mask;
            r_ready_mask <= n_ready_mask;
            r_last_alloc <= n_last_alloc;
            r_last_disp  <= n_last_disp;
            r_owner_vld  <= n_owner_vld;
            r_owner_idx  <= n_owner_idx;
            r_succ_vld   <= n_succ_vld;
            r_succ_idx   <= n_succ_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_word <= i_in_word;
        end
        if (proc) begin
            r_out_word <= n_out_word;
        end
    end

    `BDH_ASSERT_IMP(a_free_ready_disjoint, i_clk, i_rst_n, 1'b1,
                    (r_free_mask & r_ready_mask) == '0)
    `BDH_ASSERT_NXT(a_held_word_stable, i_clk, i_rst_n, r_in_valid && o_in_stall,
                    r_in_valid && $stable(r_in_word))
    `BDH_ASSERT_IMP(a_result_kind, i_clk, i_rst_n, o_out_valid,
                    !(o_out_word.alloc_ok && (o_out_word.dispatched || o_out_word.freed)))

endmodule

// File: src/bdh_pick.sv
// ----------------------------------------------------------------------------
// bdh_pick
// Picks the highest set bit below a limit, else the highest set bit.
// ----------------------------------------------------------------------------
module bdh_pick #(
    parameter int N = bdh_pkg::NUM_BLOCKS_DEF
) (
    input  logic [N-1:0]         i_mask,
    input  logic [$clog2(N)-1:0] i_limit,
    output logic                 o_found,
    output logic [$clog2(N)-1:0] o_idx
);

    localparam int IW = $clog2(N);

    logic          below_found;
    logic [IW-1:0] below_idx;
    logic [IW-1:0] any_idx;

    always_comb begin
        below_found = 1'b0;
        below_idx   = '0;
        any_idx     = '0;
        for (int i = 0; i < N; i++) begin
            if (i_mask[i]) begin
                any_idx = IW'(i);
                if (IW'(i) < i_limit) begin
                    below_found = 1'b1;
                    below_idx   = IW'(i);
                end
            end
        end
        o_found = |i_mask;
        o_idx   = below_found ? below_idx : any_idx;
    end

endmodule

// File: src/bdh_tags.sv
// ----------------------------------------------------------------------------
// bdh_tags
// Hazard tag store with parallel compare; lowest matching entry reported.
// ----------------------------------------------------------------------------
module bdh_tags #(
    parameter int NUM_BLOCKS = bdh_pkg::NUM_BLOCKS_DEF,
    parameter int TAG_BITS   = bdh_pkg::TAG_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [TAG_BITS-1:0]           i_tag,
    output logic                          o_match,
    output logic [$clog2(NUM_BLOCKS)-1:0] o_match_idx,
    input  logic                          i_alloc_we,
    input  logic [$clog2(NUM_BLOCKS)-1:0] i_alloc_idx,
    input  logic                          i_clear_we,
    input  logic [$clog2(NUM_BLOCKS)-1:0] i_clear_idx
);

    localparam int IW = $clog2(NUM_BLOCKS);
    localparam logic [TAG_BITS-1:0] EMPTY_TAG = '1;

    logic [TAG_BITS-1:0]   r_tag_store [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] hit;
    logic [IW-1:0]         low_idx;

    always_comb begin
        low_idx = '0;
        for (int i = NUM_BLOCKS - 1; i >= 0; i--) begin
            hit[i] = (r_tag_store[i] == i_tag) && (i_tag != EMPTY_TAG);
            if (hit[i]) begin
                low_idx = IW'(i);
            end
        end
        o_match     = |hit;
        o_match_idx = low_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BLOCKS; i++) begin
                r_tag_store[i] <= EMPTY_TAG;
            end
        end else begin
            for (int i = 0; i < NUM_BLOCKS; i++) begin
                if (i_alloc_we && (i_alloc_idx == IW'(i))) begin
                    r_tag_store[i] <= i_tag;
                end else if (i_alloc_we && hit[i]) begin
                    r_tag_store[i] <= EMPTY_TAG;
                end else if (i_clear_we && (i_clear_idx == IW'(i))) begin
                    r_tag_store[i] <= EMPTY_TAG;
                end
            end
        end
    end

endmodule
